// ----- rtl/core/mpm_pkg.sv -----
// Shared constants, field widths and operation codes of the multi-pattern matcher.
package mpm_pkg;

    // Default sizes handed to the top level
    localparam int SLOT_COUNT_DEF      = 16;
    localparam int MAX_PATTERN_LEN_DEF = 64;
    localparam int POSITION_BITS_DEF   = 32;

    // Results given per text byte at most
    localparam int MAX_RESULTS = 16;

    // Payload field widths
    localparam int OP_W             = 2;
    localparam int PATTERN_FIELD_W  = 4;
    localparam int INDEX_FIELD_W    = 6;
    localparam int LENGTH_FIELD_W   = 7;
    localparam int BYTE_W           = 8;
    localparam int START_W          = 32;

    // Largest value the start field can carry
    localparam logic [START_W-1:0] START_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_BYTE = 2'd0,
        OP_SET_LENGTH = 2'd1,
        OP_TEXT_BYTE  = 2'd2,
        OP_NEW_TEXT   = 2'd3
    } op_t;

endpackage

// ----- rtl/core/mpm_cmd_if.sv -----
// Command channel: pattern loads, length writes, text bytes and text restarts.
interface mpm_cmd_if;
    import mpm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [PATTERN_FIELD_W-1:0] pattern_number;
    logic [INDEX_FIELD_W-1:0]   byte_index;
    logic [LENGTH_FIELD_W-1:0]  pattern_length;
    logic [BYTE_W-1:0]          data_byte;

    modport source
    (
        output valid,
        output operation,
        output pattern_number,
        output byte_index,
        output pattern_length,
        output data_byte,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  operation,
        input  pattern_number,
        input  byte_index,
        input  pattern_length,
        input  data_byte,
        output ready
    );

endinterface

// ----- rtl/core/mpm_result_if.sv -----
// Result channel: one item per pattern occurrence found.
interface mpm_result_if;
    import mpm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [PATTERN_FIELD_W-1:0] match_pattern;
    logic [START_W-1:0]         start_position;
    logic                       position_saturated;
    logic                       last;

    modport source
    (
        output valid,
        output match_pattern,
        output start_position,
        output position_saturated,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  match_pattern,
        input  start_position,
        input  position_saturated,
        input  last,
        output ready
    );

endinterface

// ----- rtl/core/multi_pattern_matcher.sv -----
// Top level of the multi-pattern matcher: pattern memory, scan control and result staging.
//
// Usage: the cmd channel carries four kinds of item. A pattern byte write stores one
// byte into a slot, a length write enables a slot (zero disables it, lengths above
// the maximum are clipped), a text byte runs one scan, and a new-text item clears
// the position counter. The result channel gives one item per occurrence, in slot
// order, with the start offset and the saturation flag; last marks the final item
// of a text byte. A text byte with no occurrence gives no item.
// Throughput: the pattern rows sit in one row-wide memory with a single registered read
// port, read one row a cycle unless the scan stalls. A new command is not accepted
// until the scan of the last text byte is through.
// Output: the first result of a byte reaches the output register when another
// occurrence is found in a later row; otherwise it waits in the pending register
// until the scan ends.
// Reset: all slots disabled and the position counter cleared; pattern bytes are
// undefined until written. The window needs no clearing pass.
// Stall: a waiting result sits in the output register and one more in a pending
// register; when both are full and another occurrence is found, the scan holds
// until the receiver takes the output.
module multi_pattern_matcher #(
    parameter int SLOT_COUNT      = mpm_pkg::SLOT_COUNT_DEF,
    parameter int MAX_PATTERN_LEN = mpm_pkg::MAX_PATTERN_LEN_DEF,
    parameter int POSITION_BITS   = mpm_pkg::POSITION_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    mpm_cmd_if.sink      cmd,
    mpm_result_if.source result
);
    import mpm_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W  = $clog2(MAX_PATTERN_LEN);
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int ROW_W  = MAX_PATTERN_LEN * BYTE_W;
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int PW     = POSITION_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Command decode
    logic             cmd_fire;
    op_t              cmd_op;
    logic [6:0]       slot_ext;
    logic [8:0]       bidx_ext;
    logic [8:0]       plen_ext;
    logic             slot_ok;
    logic             bidx_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic [IDX_W-1:0] lane_idx;
    logic [LEN_W-1:0] len_sat;
    logic             wr_byte_en;
    logic             wr_len_en;
    logic             text_en;
    logic             clear_en;

    // Storage
    logic [ROW_W-1:0]         pat_mem [SLOT_COUNT];
    logic [LEN_W-1:0]         len_reg [SLOT_COUNT];
    logic [ROW_W-1:0]         win_reg;
    logic [POSITION_BITS-1:0] count_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     sat_reg;

    // Scan control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [RES_W-1:0] res_cnt_reg, res_cnt_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] scan_idx;
    logic             issue;
    logic             take;
    logic             out_free;
    logic             stall;
    logic             adv;
    logic             rd_en;
    logic             pend_load;
    logic             scan_done;
    logic             out_load_mid;
    logic             out_load_end;
    logic             out_load;

    // Compare stage
    logic [ROW_W-1:0]  rd_row_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [LEN_W-1:0]  s1_len_reg;
    logic              row_hit;
    logic              s1_match;
    logic [PW-1:0]     pos_p1;
    logic [PW-1:0]     start_full;
    logic [63:0]       start_wide;
    logic [START_W-1:0] start_clip;

    // Result staging
    logic [PATTERN_FIELD_W-1:0] pend_pat_reg;
    logic [START_W-1:0]         pend_start_reg;
    logic [PATTERN_FIELD_W-1:0] out_pat_reg;
    logic [START_W-1:0]         out_start_reg;
    logic                       out_sat_reg;
    logic                       out_last_reg;

    // Decode the command item
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd_op    = op_t'(cmd.operation);
    assign slot_ext  = 7'(cmd.pattern_number);
    assign bidx_ext  = 9'(cmd.byte_index);
    assign plen_ext  = 9'(cmd.pattern_length);
    assign slot_ok   = slot_ext < 7'(SLOT_COUNT);
    assign bidx_ok   = bidx_ext < 9'(MAX_PATTERN_LEN);
    assign slot_idx  = slot_ext[SLOT_W-1:0];
    assign lane_idx  = bidx_ext[IDX_W-1:0];
    assign len_sat   = (plen_ext > 9'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN)
                                                        : plen_ext[LEN_W-1:0];

    always_comb
    begin
        wr_byte_en = 1'b0;
        wr_len_en  = 1'b0;
        text_en    = 1'b0;
        clear_en   = 1'b0;
        if (cmd_fire)
        begin
            case (cmd_op)
                OP_WRITE_BYTE: wr_byte_en = slot_ok && bidx_ok;
                OP_SET_LENGTH: wr_len_en  = slot_ok;
                OP_TEXT_BYTE:  text_en    = 1'b1;
                OP_NEW_TEXT:   clear_en   = 1'b1;
                default:       wr_byte_en = 1'b0;
            endcase
        end
    end

    assign cmd.ready = (state_reg == ST_IDLE);

    // Pattern rows: byte-lane write, row-wide registered read
    always_ff @(posedge clk)
    begin
        if (wr_byte_en)
        begin
            pat_mem[slot_idx][{lane_idx, 3'b000} +: BYTE_W] <= cmd.data_byte;
        end
        if (rd_en)
        begin
            rd_row_reg <= pat_mem[scan_idx];
        end
    end

    // Pattern lengths; zero disables a slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (wr_len_en)
        begin
            len_reg[slot_idx] <= len_sat;
        end
    end

    // Saturating text position counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (clear_en)
        begin
            count_reg <= '0;
        end
        else if (text_en && !(&count_reg))
        begin
            count_reg <= count_reg + POSITION_BITS'(1);
        end
    end

    // Shift the text byte into the window and hold its position
    always_ff @(posedge clk)
    begin
        if (text_en)
        begin
            win_reg <= {cmd.data_byte, win_reg[ROW_W-1:BYTE_W]};
            pos_reg <= count_reg;
            sat_reg <= &count_reg;
        end
    end

    // Compare one row against the window
    mpm_row_compare #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_row_compare (
        .row    (rd_row_reg),
        .window (win_reg),
        .len    (s1_len_reg),
        .hit    (row_hit)
    );

    // Occurrence needs an enabled slot and enough text since the restart
    assign pos_p1     = {1'b0, pos_reg} + PW'(1);
    assign start_full = pos_p1 - PW'(s1_len_reg);
    assign start_wide = 64'(start_full);
    assign start_clip = (start_wide > 64'(START_MAX)) ? START_MAX : start_wide[START_W-1:0];
    assign s1_match   = row_hit && (s1_len_reg != '0) && (pos_p1 >= PW'(s1_len_reg));

    // Scan handshake between compare stage, pending and output registers
    assign scan_idx     = scan_cnt_reg[SLOT_W-1:0];
    assign issue        = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_W'(SLOT_COUNT));
    assign take         = s1_valid_reg && s1_match && (res_cnt_reg < RES_W'(MAX_RESULTS));
    assign out_free     = !out_valid_reg || result.ready;
    assign stall        = take && pend_valid_reg && !out_free;
    assign adv          = !stall;
    assign rd_en        = issue && adv;
    assign pend_load    = take && adv;
    assign scan_done    = (state_reg == ST_SCAN) && !issue && !s1_valid_reg;
    assign out_load_mid = pend_load && pend_valid_reg;
    assign out_load_end = scan_done && pend_valid_reg && out_free;
    assign out_load     = out_load_mid || out_load_end;

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        res_cnt_next    = res_cnt_reg;
        s1_valid_next   = s1_valid_reg;
        pend_valid_next = pend_valid_reg;

        if (text_en)
        begin
            state_next    = ST_SCAN;
            scan_cnt_next = '0;
            res_cnt_next  = '0;
        end
        if (rd_en)
        begin
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        end
        if (adv)
        begin
            s1_valid_next = issue;
        end
        if (pend_load)
        begin
            pend_valid_next = 1'b1;
            res_cnt_next    = res_cnt_reg + RES_W'(1);
        end
        if (scan_done && (!pend_valid_reg || out_free))
        begin
            state_next      = ST_IDLE;
            pend_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            res_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            res_cnt_reg    <= res_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Advance the compare stage and the result payloads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_slot_reg <= scan_idx;
            s1_len_reg  <= len_reg[scan_idx];
        end
        if (pend_load)
        begin
            pend_pat_reg   <= PATTERN_FIELD_W'(s1_slot_reg);
            pend_start_reg <= start_clip;
        end
        if (out_load)
        begin
            out_pat_reg   <= pend_pat_reg;
            out_start_reg <= pend_start_reg;
            out_sat_reg   <= sat_reg;
            out_last_reg  <= out_load_end;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.match_pattern      = out_pat_reg;
    assign result.start_position     = out_start_reg;
    assign result.position_saturated = out_sat_reg;
    assign result.last               = out_last_reg;

    // Output register is never reloaded while its item is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result overwritten before it was taken");

    // The closing item of a byte empties the pending register and ends the scan
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_load_end |=> (!pend_valid_reg && state_reg == ST_IDLE))
        else $error("scan did not close after last item");

    // Nothing is in flight while commands are accepted
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_valid_reg && !pend_valid_reg))
        else $error("scan pipeline busy while idle");

    // Result count per byte stays within bounds
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_W'(MAX_RESULTS))
        else $error("too many results for one text byte");

endmodule

// ----- rtl/core/mpm_row_compare.sv -----
// Aligns the text window to one pattern row and compares every byte lane.
module mpm_row_compare #(
    parameter int MAX_PATTERN_LEN = mpm_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic [MAX_PATTERN_LEN*mpm_pkg::BYTE_W-1:0] row,
    input  logic [MAX_PATTERN_LEN*mpm_pkg::BYTE_W-1:0] window,
    input  logic [$clog2(MAX_PATTERN_LEN+1)-1:0]       len,
    output logic                                       hit
);
    import mpm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int ROW_W = MAX_PATTERN_LEN * BYTE_W;

    logic [LEN_W-1:0]           gap;
    logic [ROW_W-1:0]           aligned;
    logic [MAX_PATTERN_LEN-1:0] lane_ok;

    // Window holds the oldest byte in lane 0; drop the bytes older than the pattern
    assign gap     = LEN_W'(MAX_PATTERN_LEN) - len;
    assign aligned = window >> {gap, 3'b000};

    // Compare each lane; lanes past the pattern end always pass
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++)
        begin
            lane_ok[i] = (row[i*BYTE_W +: BYTE_W] == aligned[i*BYTE_W +: BYTE_W])
                         || (LEN_W'(i) >= len);
        end
    end

    assign hit = &lane_ok;

endmodule
